// ===== sv/ycc2rgb_pkg.sv =====
// Package for the YCbCr 4:2:2 / RGB565 to 32-bit RGB converter.
// Holds the request payload types, the format codes and the coefficient helper.
// No dependencies.
package ycc2rgb_pkg;

    // Default number of fraction bits in the conversion coefficients.
    localparam int COEF_FRAC_BITS_DEF = 10;

    // Video-range offsets of the luma and chroma samples.
    localparam int LUMA_OFFSET   = 16;
    localparam int CHROMA_OFFSET = 128;

    // Largest value of one output channel.
    localparam int CHAN_MAX = 255;

    // Source format held in the mode register.
    typedef enum logic [0:0] {
        FMT_YCBCR  = 1'b0,
        FMT_RGB565 = 1'b1
    } src_fmt_t;

    // One input request: a 4:2:2 macropixel or one packed RGB565 pixel.
    typedef struct packed {
        logic [7:0]  luma_first;
        logic [7:0]  chroma_blue;
        logic [7:0]  luma_second;
        logic [7:0]  chroma_red;
        logic        second_present;
        logic [15:0] packed_565;
    } in_item_t;

    // One output request: one RGB pixel with eight bits per channel.
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_of_item;
    } out_item_t;

    // Coefficient given in thousandths, scaled by 2^frac and rounded half up.
    function automatic int coef_of(input int milli, input int frac);
        return (milli * (1 << frac) + 500) / 1000;
    endfunction

endpackage

// ===== sv/ycbcr422_rgb565_to_rgb32.sv =====
// YCbCr 4:2:2 / RGB565 to 32-bit RGB converter, top level.
// An accepted request waits in the input register; its pixels pass through the single
// converter into the output register, the second after the first, one pixel a cycle unless
// out_ready stalls them; a new request is taken as the last pixel of the held one is issued.
// Reset (rst_n, asynchronous, active low) empties both stages and selects YCbCr mode.
// Depends on ycc2rgb_pkg and ycc2rgb_pixel.
module ycbcr422_rgb565_to_rgb32 #(
    parameter int COEF_FRAC_BITS = ycc2rgb_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ycc2rgb_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ycc2rgb_pkg::out_item_t out_data
);

    ycc2rgb_pkg::src_fmt_t  fmt_reg;
    ycc2rgb_pkg::in_item_t  hold_reg;
    ycc2rgb_pkg::in_item_t  hold_next;
    logic                   hold_valid_reg;
    logic                   hold_valid_next;
    logic                   phase_reg;
    logic                   phase_next;
    ycc2rgb_pkg::out_item_t out_reg;
    ycc2rgb_pkg::out_item_t out_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    ycc2rgb_pkg::out_item_t pixel;
    logic                   out_free;
    logic                   issue;
    logic                   done;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= ycc2rgb_pkg::FMT_YCBCR;
        end
        else if (cfg_we)
        begin
            fmt_reg <= ycc2rgb_pkg::src_fmt_t'(cfg_wdata);
        end
    end

    // Pixel converter between the input register and the output register.
    ycc2rgb_pixel #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_pixel (
        .source_format(fmt_reg),
        .item         (hold_reg),
        .second_phase (phase_reg),
        .pixel        (pixel)
    );

    // A pixel moves on whenever the output register is empty or being emptied.
    assign out_free = !out_valid_reg || out_ready;
    assign issue    = hold_valid_reg && out_free;
    assign done     = issue && pixel.last_of_item;
    assign in_ready = !hold_valid_reg || done;

    // Next state of the input register and the pixel phase.
    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        phase_next      = phase_reg;
        if (in_valid && in_ready)
        begin
            hold_next       = in_data;
            hold_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
        else if (done)
        begin
            hold_valid_next = 1'b0;
            phase_next      = 1'b0;
        end
        else if (issue)
        begin
            phase_next = 1'b1;
        end
    end

    // Next state of the output register.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            out_next       = pixel;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/ycc2rgb_pixel.sv =====
// Combinational pixel converter: BT.601 YCbCr to RGB, or RGB565 unpacking.
// Depends on ycc2rgb_pkg for the payload types, format codes and coefficients.
module ycc2rgb_pixel #(
    parameter int COEF_FRAC_BITS = ycc2rgb_pkg::COEF_FRAC_BITS_DEF
) (
    input  ycc2rgb_pkg::src_fmt_t  source_format,
    input  ycc2rgb_pkg::in_item_t  item,
    input  logic                   second_phase,
    output ycc2rgb_pkg::out_item_t pixel
);

    // Sum width: ten integer bits cover every channel sum, plus margin and sign.
    localparam int SW = COEF_FRAC_BITS + 12;

    localparam logic signed [SW-1:0] K1164 = SW'(ycc2rgb_pkg::coef_of(1164, COEF_FRAC_BITS));
    localparam logic signed [SW-1:0] K1596 = SW'(ycc2rgb_pkg::coef_of(1596, COEF_FRAC_BITS));
    localparam logic signed [SW-1:0] K0813 = SW'(ycc2rgb_pkg::coef_of(813, COEF_FRAC_BITS));
    localparam logic signed [SW-1:0] K0392 = SW'(ycc2rgb_pkg::coef_of(392, COEF_FRAC_BITS));
    localparam logic signed [SW-1:0] K2017 = SW'(ycc2rgb_pkg::coef_of(2017, COEF_FRAC_BITS));

    // Clamp a signed fixed-point sum to one 8-bit channel, dropping the fraction.
    function automatic logic [7:0] to_channel(input logic signed [SW-1:0] sum);
        logic [7:0] chan;
        if (sum[SW-1])
        begin
            chan = 8'd0;
        end
        else if (sum[SW-2:COEF_FRAC_BITS+8] != '0)
        begin
            chan = 8'(ycc2rgb_pkg::CHAN_MAX);
        end
        else
        begin
            chan = sum[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        end
        return chan;
    endfunction

    logic [7:0]           luma;
    logic signed [SW-1:0] d;
    logic signed [SW-1:0] u;
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] luma_term;
    logic signed [SW-1:0] sum_r;
    logic signed [SW-1:0] sum_g;
    logic signed [SW-1:0] sum_b;
    logic                 last;

    // Pick the luma sample of the pixel being produced and remove the offsets.
    assign luma = second_phase ? item.luma_second : item.luma_first;
    assign d = signed'(SW'(luma)) - SW'(ycc2rgb_pkg::LUMA_OFFSET);
    assign u = signed'(SW'(item.chroma_blue)) - SW'(ycc2rgb_pkg::CHROMA_OFFSET);
    assign v = signed'(SW'(item.chroma_red)) - SW'(ycc2rgb_pkg::CHROMA_OFFSET);

    // Constant-coefficient products and the three channel sums.
    assign luma_term = K1164 * d;
    assign sum_r = luma_term + K1596 * v;
    assign sum_g = luma_term - K0813 * v - K0392 * u;
    assign sum_b = luma_term + K2017 * u;

    // The final pixel of a request is the second one, or the only one.
    assign last = (source_format == ycc2rgb_pkg::FMT_RGB565) || !item.second_present
                  || second_phase;

    // Select between the YCbCr result and the shifted RGB565 fields.
    always_comb
    begin
        unique case (source_format)
            ycc2rgb_pkg::FMT_RGB565:
            begin
                pixel.red_out   = {item.packed_565[15:11], 3'b000};
                pixel.green_out = {item.packed_565[10:5], 2'b00};
                pixel.blue_out  = {item.packed_565[4:0], 3'b000};
            end
            default:
            begin
                pixel.red_out   = to_channel(sum_r);
                pixel.green_out = to_channel(sum_g);
                pixel.blue_out  = to_channel(sum_b);
            end
        endcase
        pixel.last_of_item = last;
    end

endmodule
